@@ hw/rtl/rlab_pkg.sv @@
package rlab_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OUT_W = 24;
  localparam int LMS_W = 22;
  localparam int LOG_W = 35;
  localparam int LOG_LAT = 31;
  localparam int SQ_STEPS = 30;
  localparam int LG_W = 42;
  localparam int MAG_W = 40;
  localparam int K_W = 30;
  localparam int SH = 42 - FRAC_BITS;

  localparam logic [13:0] MAT [0:2][0:2] = '{
    '{14'd3811, 14'd5783, 14'd402},
    '{14'd1967, 14'd7244, 14'd782},
    '{14'd241, 14'd1288, 14'd8444}
  };

  localparam logic [K_W-1:0] K_L = 30'd746464238;
  localparam logic [K_W-1:0] K_A = 30'd527829925;
  localparam logic [K_W-1:0] K_B = 30'd914228247;

  localparam logic [LMS_W-1:0] BLACK_S0 = 22'd2548980;
  localparam logic [LMS_W-1:0] BLACK_S1 = 22'd2548215;
  localparam logic [LMS_W-1:0] BLACK_S2 = 22'd2543115;
  localparam logic [LG_W-1:0] BLACK_OFS = 42'd126 << 30;

  // Integer log2 in Q30 by repeated squaring, evaluated at elaboration only.
  function automatic logic [63:0] log2q_const(input logic [31:0] n);
    int e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 31;
    frac = 64'd0;
    while (n[e] == 1'b0) e--;
    m = 64'(n) << (31 - e);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << 30) + frac;
  endfunction

  localparam logic [63:0] DEN64 = log2q_const(32'd2550000);
  localparam logic [LG_W-1:0] DEN = DEN64[LG_W-1:0];

endpackage

@@ hw/rtl/rlab_if.sv @@
interface rlab_in_if;
  import rlab_pkg::*;
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic frame_end;
  modport source(output valid, red, green, blue, frame_end, input ready);
  modport sink(input valid, red, green, blue, frame_end, output ready);
endinterface

interface rlab_out_if;
  import rlab_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] lightness;
  logic signed [OUT_W-1:0] alpha_axis;
  logic signed [OUT_W-1:0] beta_axis;
  logic frame_end_out;
  modport source(output valid, lightness, alpha_axis, beta_axis, frame_end_out, input ready);
  modport sink(input valid, lightness, alpha_axis, beta_axis, frame_end_out, output ready);
endinterface

@@ hw/rtl/rlab_log2.sv @@
module rlab_log2
  import rlab_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [LMS_W-1:0] s,
  output logic [LOG_W-1:0] log_q
);

  logic [4:0]  e_r    [0:SQ_STEPS];
  logic [31:0] m_r    [0:SQ_STEPS];
  logic [29:0] frac_r [0:SQ_STEPS];
  logic [4:0]  e_nxt;
  logic [31:0] m_nxt;

  always_comb begin
    e_nxt = 5'd0;
    for (int i = 0; i < LMS_W; i++) begin
      if (s[i]) begin
        e_nxt = 5'(i);
      end
    end
    m_nxt = {10'd0, s} << (5'd31 - e_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= e_nxt;
      m_r[0] <= m_nxt;
      frac_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_r[g]) * 64'(m_r[g]);
    assign t = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[g+1] <= e_r[g];
        m_r[g+1] <= t[32] ? t[32:1] : t[31:0];
        frac_r[g+1] <= {frac_r[g][28:0], t[32]};
      end
    end
  end

  assign log_q = {e_r[SQ_STEPS], frac_r[SQ_STEPS]};

endmodule

@@ hw/rtl/rgb_to_lab_pixel_converter.sv @@
// Channel  | Direction | Payload
// in_pix   | sink      | red, green, blue, frame_end
// out_pix  | source    | lightness, alpha_axis, beta_axis, frame_end_out
//
// Items enter one per cycle unless held, then pass input, log2, sum, product and output stages.
// The latency is set by the log2 unit, which spends one stage per squaring step.
// Reset clears the valid bits of all stages; payload registers are not reset.
// When the output item is held, the whole pipeline holds and in_pix.ready is low.
module rgb_to_lab_pixel_converter
  import rlab_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rlab_in_if.sink    in_pix,
  rlab_out_if.source out_pix
);

  logic en;
  logic s_valid_r;
  logic s_fe_r;
  logic s_black_r;
  logic [LMS_W-1:0] s_r [0:2];
  logic [LMS_W-1:0] s_nxt [0:2];
  logic black;

  logic [LOG_LAT-1:0] d_valid_r;
  logic [LOG_LAT-1:0] d_fe_r;
  logic [LOG_LAT-1:0] d_black_r;
  logic [LOG_W-1:0] log_q [0:2];

  logic [LG_W-1:0] lg [0:2];
  logic [LG_W-1:0] c_nxt [0:2];
  logic [LG_W-1:0] c_r [0:2];
  logic c_valid_r;
  logic c_fe_r;

  logic [K_W-1:0] kk [0:2];
  logic [49:0] ph_r [0:2];
  logic [29:0] pl_r [0:2];
  logic neg_r [0:2];
  logic p_valid_r;
  logic p_fe_r;

  logic [OUT_W-1:0] res_nxt [0:2];
  logic out_valid_r;
  logic out_fe_r;
  logic [OUT_W-1:0] res_r [0:2];

  assign en = !out_valid_r || out_pix.ready;
  assign in_pix.ready = en;
  assign black = (in_pix.red | in_pix.green | in_pix.blue) == 8'd0;

  assign kk[0] = K_L;
  assign kk[1] = K_A;
  assign kk[2] = K_B;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s_nxt[r] = 22'(MAT[r][0]) * 22'(in_pix.red) + 22'(MAT[r][1]) * 22'(in_pix.green)
               + 22'(MAT[r][2]) * 22'(in_pix.blue);
    end
    if (black) begin
      s_nxt[0] = BLACK_S0;
      s_nxt[1] = BLACK_S1;
      s_nxt[2] = BLACK_S2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      d_valid_r <= '0;
      c_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= in_pix.valid;
      d_valid_r <= {d_valid_r[LOG_LAT-2:0], s_valid_r};
      c_valid_r <= d_valid_r[LOG_LAT-1];
      p_valid_r <= c_valid_r;
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_fe_r <= in_pix.frame_end;
      s_black_r <= black;
      s_r <= s_nxt;
      d_fe_r <= {d_fe_r[LOG_LAT-2:0], s_fe_r};
      d_black_r <= {d_black_r[LOG_LAT-2:0], s_black_r};
      c_fe_r <= d_fe_r[LOG_LAT-1];
      c_r <= c_nxt;
      p_fe_r <= c_fe_r;
      out_fe_r <= p_fe_r;
      res_r <= res_nxt;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_log
    rlab_log2 u_log (
      .clk   (clk),
      .en    (en),
      .s     (s_r[g]),
      .log_q (log_q[g])
    );
    assign lg[g] = LG_W'(log_q[g]) - DEN - (d_black_r[LOG_LAT-1] ? BLACK_OFS : '0);
  end

  always_comb begin
    c_nxt[0] = lg[0] + lg[1] + lg[2];
    c_nxt[1] = lg[0] + lg[1] - (lg[2] << 1);
    c_nxt[2] = lg[0] - lg[1];
  end

  for (genvar g = 0; g < 3; g++) begin : g_scale
    logic [LG_W-1:0] mag;
    logic [MAG_W-1:0] a;
    logic [49:0] pl_full;
    logic [50:0] p;
    logic [50:0] rr;

    assign mag = c_r[g][LG_W-1] ? (LG_W'(0) - c_r[g]) : c_r[g];
    assign a = mag[MAG_W-1:0];
    assign pl_full = 50'(a[19:0]) * 50'(kk[g]);

    always_ff @(posedge clk) begin
      if (en) begin
        ph_r[g] <= 50'(a[39:20]) * 50'(kk[g]);
        pl_r[g] <= pl_full[49:20];
        neg_r[g] <= c_r[g][LG_W-1];
      end
    end

    assign p = 51'(ph_r[g]) + 51'(pl_r[g]);
    assign rr = (p + (51'd1 << (SH - 1))) >> SH;

    always_comb begin
      if (neg_r[g]) begin
        if (rr > 51'(24'h800000)) begin
          res_nxt[g] = 24'h800000;
        end else begin
          res_nxt[g] = OUT_W'(24'd0 - rr[OUT_W-1:0]);
        end
      end else begin
        if (rr > 51'(24'h7FFFFF)) begin
          res_nxt[g] = 24'h7FFFFF;
        end else begin
          res_nxt[g] = rr[OUT_W-1:0];
        end
      end
    end
  end

  assign out_pix.valid = out_valid_r;
  assign out_pix.lightness = res_r[0];
  assign out_pix.alpha_axis = res_r[1];
  assign out_pix.beta_axis = res_r[2];
  assign out_pix.frame_end_out = out_fe_r;

endmodule
